[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on clk and switched off while arst_n is low.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication: when ante holds, cons must hold at the next clock.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/todcc_pkg.sv]
// Package with the transaction types, action codes and calendar helpers of the clock.
`timescale 1ns / 1ps
`default_nettype none

package todcc_pkg;

	localparam logic [2:0] ACT_TICK     = 3'd0;
	localparam logic [2:0] ACT_SET_24H  = 3'd1;
	localparam logic [2:0] ACT_SET_12H  = 3'd2;
	localparam logic [2:0] ACT_SET_DATE = 3'd3;
	localparam logic [2:0] ACT_READ     = 3'd4;

	localparam logic [0:0] REG_RUN_ENABLE = 1'd0;

	localparam logic [5:0]  SEC_RESET   = 6'd0;
	localparam logic [5:0]  MIN_RESET   = 6'd0;
	localparam logic [4:0]  HOUR_RESET  = 5'd12;
	localparam logic [4:0]  DAY_RESET   = 5'd1;
	localparam logic [3:0]  MONTH_RESET = 4'd1;
	localparam logic [15:0] YEAR_RESET  = 16'd2009;

	localparam logic [6:0] SECS_PER_MIN  = 7'd60;
	localparam logic [6:0] MINS_PER_HOUR = 7'd60;
	localparam logic [5:0] HOURS_PER_DAY = 6'd24;
	localparam logic [4:0] NOON          = 5'd12;
	localparam logic [4:0] MONTHS        = 5'd12;

	// Month lengths, indexed by month; months 0 and 13 to 15 have no days.
	localparam logic [4:0] MONTH_LEN [16] = '{
		5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
		5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
	};
	localparam logic [3:0] FEBRUARY = 4'd2;

	// A 16-bit value is a multiple of 25 exactly when its product with the
	// inverse of 25 modulo 2^16 falls at or below floor(65535 / 25).
	localparam logic [15:0] DIV25_INV   = 16'd23593;
	localparam logic [15:0] DIV25_LIMIT = 16'd2621;

	typedef struct packed {
		logic [2:0]  action;
		logic [5:0]  new_second;
		logic [5:0]  new_minute;
		logic [4:0]  new_hour;
		logic        new_is_pm;
		logic [4:0]  new_day;
		logic [3:0]  new_month;
		logic [15:0] new_year;
	} req_t;

	typedef struct packed {
		logic [5:0]  sec_now;
		logic [5:0]  min_now;
		logic [4:0]  hour_full;
		logic [3:0]  hour_half;
		logic        is_afternoon;
		logic [4:0]  day_now;
		logic [3:0]  month_now;
		logic [15:0] year_now;
	} rsp_t;

	// Gregorian leap year: divisible by 4, and not by 100 unless by 400.
	// With divisibility by 4 given, 100 reduces to 25 and 400 to 16.
	function automatic logic is_leap(input logic [15:0] year);
		logic [15:0] prod;
		prod = 16'(year * DIV25_INV);
		return (year[1:0] == 2'd0) && ((prod > DIV25_LIMIT) || (year[3:0] == 4'd0));
	endfunction

	function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		len = MONTH_LEN[month];
		if (month == FEBRUARY && leap) begin
			len = len + 5'd1;
		end
		return len;
	endfunction

endpackage

`default_nettype wire

[rtl/core/time_of_day_calendar_clock.sv]
// Top level of the time-of-day and calendar clock with its APB register port.
// Usage:
//   Requests arrive on req_valid / req_ready / req. Each transaction carries an
//   action: tick, set time in 24-hour form, set time in 12-hour form, set date,
//   or read only (unused action codes also read only). A tick advances the time
//   by one second, carrying into the date, only while run_enable is set.
//   Every request produces exactly one response on rsp_valid / rsp_ready / rsp,
//   holding the time (24-hour and 12-hour with an afternoon flag) and the date
//   as they stand after that request.
// Timing and throughput:
//   The response is presented in the cycle after the request is taken. One request is taken
//   every cycle unless an untaken response holds it back, as the carry chain and leap-year test are combinational.
// Stalls:
//   The response register is the only buffer. While it holds a response that
//   has not been taken, req_ready is low; it rises in the cycle the response
//   is taken, so a new request can enter in that same cycle.
// Reset:
//   arst_n clears the response valid flag and loads 12:00:00 on 1 January 2009
//   with the clock stopped (run_enable low).
// Register: run_enable at byte address 0, written through the APB port.
`timescale 1ns / 1ps
`default_nettype none

module time_of_day_calendar_clock
	import todcc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire req_t        req,

	output logic             rsp_valid,
	input  wire logic        rsp_ready,
	output rsp_t             rsp,

	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	`include "assert_macros.svh"

	// Time and date registers.
	logic [5:0]  sec_q;
	logic [5:0]  min_q;
	logic [4:0]  hour_q;
	logic [4:0]  day_q;
	logic [3:0]  month_q;
	logic [15:0] year_q;
	logic        run_q;

	// Response register.
	logic        rsp_valid_q;
	rsp_t        rsp_q;

	logic        req_fire;
	logic        cfg_write;

	// Tick arithmetic, widened by one bit so that wrap tests see the carry.
	logic [6:0]  sec_inc;
	logic [6:0]  min_inc;
	logic [5:0]  hour_inc;
	logic [5:0]  day_inc;
	logic [4:0]  month_inc;
	logic        sec_wrap;
	logic        min_wrap;
	logic        hour_wrap;
	logic        day_wrap;
	logic        month_wrap;
	logic [4:0]  month_len;
	logic [4:0]  hour_12h_set;

	logic [5:0]  sec_d;
	logic [5:0]  min_d;
	logic [4:0]  hour_d;
	logic [4:0]  day_d;
	logic [3:0]  month_d;
	logic [15:0] year_d;
	logic [3:0]  half_d;

	// Packed views of the clock and of the response, and the requests the checks look at.
	logic [41:0] clock_state;
	logic [41:0] rsp_state;
	logic        stopped_tick;
	logic        read_fire;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign req_fire  = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The APB port never waits; a write lands in the access phase.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == REG_RUN_ENABLE) ? {31'd0, run_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else if (cfg_write && paddr[2] == REG_RUN_ENABLE) begin
			run_q <= pwdata[0];
		end
	end

	// The carry chain of a one-second advance. Out-of-range stored values
	// (set without checks) wrap on the next carry, time to 0, day/month to 1,
	// and months outside 1 to 12 have no days, so a day carry rolls the month over.
	always_comb begin
		sec_inc    = {1'b0, sec_q} + 7'd1;
		min_inc    = {1'b0, min_q} + 7'd1;
		hour_inc   = {1'b0, hour_q} + 6'd1;
		day_inc    = {1'b0, day_q} + 6'd1;
		month_inc  = {1'b0, month_q} + 5'd1;
		month_len  = month_days(month_q, is_leap(year_q));
		sec_wrap   = sec_inc >= SECS_PER_MIN;
		min_wrap   = min_inc >= MINS_PER_HOUR;
		hour_wrap  = hour_inc >= HOURS_PER_DAY;
		day_wrap   = day_inc > {1'b0, month_len};
		month_wrap = month_inc > MONTHS;

		// 12 AM is hour 0 and 12 PM is hour 12; the sum keeps five bits.
		hour_12h_set = (req.new_hour == NOON) ? 5'd0 : req.new_hour;
		if (req.new_is_pm) begin
			hour_12h_set = hour_12h_set + NOON;
		end

		sec_d   = sec_q;
		min_d   = min_q;
		hour_d  = hour_q;
		day_d   = day_q;
		month_d = month_q;
		year_d  = year_q;

		case (req.action)
			ACT_TICK: begin
				if (run_q) begin
					sec_d = sec_wrap ? 6'd0 : sec_inc[5:0];
					if (sec_wrap) begin
						min_d = min_wrap ? 6'd0 : min_inc[5:0];
						if (min_wrap) begin
							hour_d = hour_wrap ? 5'd0 : hour_inc[4:0];
							if (hour_wrap) begin
								day_d = day_wrap ? 5'd1 : day_inc[4:0];
								if (day_wrap) begin
									month_d = month_wrap ? 4'd1 : month_inc[3:0];
									if (month_wrap) begin
										year_d = year_q + 16'd1;
									end
								end
							end
						end
					end
				end
			end
			ACT_SET_24H: begin
				sec_d  = req.new_second;
				min_d  = req.new_minute;
				hour_d = req.new_hour;
			end
			ACT_SET_12H: begin
				sec_d  = req.new_second;
				min_d  = req.new_minute;
				hour_d = hour_12h_set;
			end
			ACT_SET_DATE: begin
				day_d   = req.new_day;
				month_d = req.new_month;
				year_d  = req.new_year;
			end
			default: begin
			end
		endcase

		// Twelve-hour view: midnight shows as 12, afternoon hours drop by 12.
		if (hour_d == 5'd0) begin
			half_d = 4'd12;
		end else if (hour_d > NOON) begin
			half_d = 4'(hour_d - NOON);
		end else begin
			half_d = hour_d[3:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q   <= SEC_RESET;
			min_q   <= MIN_RESET;
			hour_q  <= HOUR_RESET;
			day_q   <= DAY_RESET;
			month_q <= MONTH_RESET;
			year_q  <= YEAR_RESET;
		end else if (req_fire) begin
			sec_q   <= sec_d;
			min_q   <= min_d;
			hour_q  <= hour_d;
			day_q   <= day_d;
			month_q <= month_d;
			year_q  <= year_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (req_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Response payload needs no reset; it is only looked at while valid.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			rsp_q.sec_now      <= sec_d;
			rsp_q.min_now      <= min_d;
			rsp_q.hour_full    <= hour_d;
			rsp_q.hour_half    <= half_d;
			rsp_q.is_afternoon <= hour_d >= NOON;
			rsp_q.day_now      <= day_d;
			rsp_q.month_now    <= month_d;
			rsp_q.year_now     <= year_d;
		end
	end

	assign clock_state  = {sec_q, min_q, hour_q, day_q, month_q, year_q};
	assign rsp_state    = {rsp_q.sec_now, rsp_q.min_now, rsp_q.hour_full,
		rsp_q.day_now, rsp_q.month_now, rsp_q.year_now};
	assign stopped_tick = req_fire && req.action == ACT_TICK && !run_q;
	assign read_fire    = req_fire && req.action == ACT_READ;

	// The response always mirrors the state the request has just left behind.
	`ASSERT_NEXT(a_rsp_matches_state, req_fire, rsp_valid_q && rsp_state == clock_state, "stale response")

	// A tick with the clock stopped leaves every time and date register alone.
	`ASSERT_NEXT(a_stopped_tick, stopped_tick, $stable(clock_state), "stopped tick moved the clock")

	// A read-only request changes nothing.
	`ASSERT_NEXT(a_read_holds, read_fire, $stable(clock_state), "read request changed the clock")

	// A pending response that is not taken must not be overwritten by a new request.
	`ASSERT_CLK(a_no_overwrite, !(req_fire && rsp_valid_q && !rsp_ready), "response overwritten")

endmodule

`default_nettype wire
